// ----- rtl/pidff_pkg.sv -----
// Shared constants, register indexes, request codes and sequencer states for the
// PID controller with feedforward and integral cut. No dependencies.
`timescale 1ns / 1ps

package pidff_pkg;

  // Q16.16 datapath widths.
  localparam int DATA_WIDTH = 32;
  localparam int INTEG_W    = 48;
  localparam int DT_W       = 16;
  localparam int DIFF_W     = DATA_WIDTH + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int THR_W      = 31;

  // Serial multiplier: 48-bit multiplicand, 32-bit multiplier, one bit per step.
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Serial restoring divider: 48-bit dividend, 16-bit divisor, one bit per step.
  localparam int DIV_N_W   = 48;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Gain products are clamped to 2^60 in magnitude; the running sum needs 63 bits.
  localparam int TERM_MAG_W = 61;
  localparam int SUM_W      = 63;
  localparam int Q_FRAC     = 16;

  localparam logic [MUL_P_W-Q_FRAC-1:0] TERM_LIMIT = (MUL_P_W - Q_FRAC)'(1) << 60;
  localparam logic [DIV_D_W-1:0]        DT_SCALE_D = DIV_D_W'(1000);
  localparam logic [MUL_B_W-1:0]        DT_SCALE_M = MUL_B_W'(1000);

  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [INTEG_W-1:0]    INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0]    INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Request codes.
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDFORWARD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT      = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MI_GO,
    S_MI_WAIT,
    S_DI_GO,
    S_DI_WAIT,
    S_INTEG,
    S_MD_GO,
    S_MD_WAIT,
    S_DD_GO,
    S_DD_WAIT,
    S_KP_GO,
    S_KP_WAIT,
    S_KI_GO,
    S_KI_WAIT,
    S_KD_GO,
    S_KD_WAIT,
    S_SUM,
    S_DONE
  } seq_state_t;

endpackage

// ----- rtl/pidff_mul.sv -----
// Bit-serial shift-add multiplier: 48 x 32 unsigned, one multiplier bit per cycle.
// Depends on pidff_pkg for widths.
`timescale 1ns / 1ps

module pidff_mul
  import pidff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MUL_A_W-1:0]   a_r, a_nxt;
  logic [MUL_A_W-1:0]   hi_r, hi_nxt;
  logic [MUL_B_W-1:0]   b_r, b_nxt;
  logic [MUL_A_W:0]     add_sum;

  // The low product bits shift into the multiplier register as it empties.
  always_comb begin
    add_sum  = {1'b0, hi_r} + (b_r[0] ? {1'b0, a_r} : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MUL_CNT_W'(MUL_B_W - 1);
      a_nxt    = a;
      hi_nxt   = '0;
      b_nxt    = b;
    end else if (busy_r) begin
      hi_nxt = add_sum[MUL_A_W:1];
      b_nxt  = {add_sum[0], b_r[MUL_B_W-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    b_r  <= b_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, b_r};

endmodule

// ----- rtl/pidff_div.sv -----
// Bit-serial restoring divider: 48-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Depends on pidff_pkg for widths.
`timescale 1ns / 1ps

module pidff_div
  import pidff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_N_W-1:0] quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r, den_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     trial_sub;
  logic                 fits;

  // Dividend bits leave the top of quo_r while quotient bits enter at the bottom.
  always_comb begin
    trial     = {rem_r, quo_r[DIV_N_W-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = trial >= {1'b0, den_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      rem_nxt = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/pid_feedforward_integral_cut_unit.sv -----
// Top level of the PID controller with feedforward and integral cut: sequencer,
// Q16.16 datapath and configuration registers. Uses pidff_pkg, pidff_mul, pidff_div.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on in_valid/in_ready with in_func, in_sensor and in_dt_ms; each
// request gives exactly one result on out_valid/out_ready (out_drive, out_saturated).
// Registers are written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes should only be made while the block is idle.
// One request is worked on at a time. An update while running goes from acceptance
// through five passes of the serial multiplier (each a launch, 32 one-bit steps and
// a finish), two passes of the serial divider (each a launch, 48 one-bit steps and a
// finish), the integral step, the final sum and the hand-off, and then back to the
// idle state that accepts the next request. Start, reset, an update while stopped
// and the unused code go from idle straight to the hand-off. The result is loaded
// into the output register at the same edge at which the sequencer returns to idle.
// A stalled receiver does not block acceptance of the next request, but that
// request's result waits until the output register has been emptied, and no
// further request is accepted until then.
// Reset (rst_n low at a clock edge) clears the configuration registers, the
// integral, the previous error and the running flag, and drops out_valid.

module pid_feedforward_integral_cut_unit
  import pidff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_sensor,
  input  logic [DT_W-1:0]       in_dt_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_drive,
  output logic                  out_saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  seq_state_t state_r, state_nxt;

  // Configuration.
  logic [DATA_WIDTH-1:0] ff_r, kp_r, ki_r, kd_r, setpoint_r;
  logic                  cut_en_r;
  logic [THR_W-1:0]      thr_r;

  // Controller state.
  logic                  running_r;
  logic [INTEG_W-1:0]    integral_r;
  logic [DATA_WIDTH-1:0] last_err_r;

  // Per-request working registers.
  logic [DATA_WIDTH-1:0] err_r;
  logic [DT_W-1:0]       dt_r;
  logic [DIFF_W-1:0]     diff_r;
  logic                  sat_r;
  logic [SUM_W-1:0]      sum_r;
  logic [DATA_WIDTH-1:0] res_drive_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_drive_r;
  logic                  out_sat_r;

  logic accept, is_update, out_free;

  // Serial unit requests.
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [DIV_N_W-1:0] div_quo;
  logic               term_neg;

  // Combinational datapath.
  logic [DIFF_W-1:0]             err_wide;
  logic [DATA_WIDTH-1:0]         err_nxt;
  logic                          err_ovf;
  logic [DATA_WIDTH-1:0]         err_mag;
  logic [DIFF_W-1:0]             diff_mag;
  logic [DIFF_W-1:0]             diff_nxt;
  logic [INTEG_W-1:0]            integ_mag;
  logic [DATA_WIDTH-1:0]         kp_mag, ki_mag, kd_mag;
  logic [INTEG_W:0]              inc_val;
  logic [INTEG_W:0]              integ_wide;
  logic                          integ_ovf;
  logic [INTEG_W-1:0]            integ_sat;
  logic                          cut_hit;
  logic [INTEG_W-1:0]            integral_nxt;
  logic [MUL_P_W-Q_FRAC-1:0]     prod_q;
  logic [TERM_MAG_W-1:0]         term_mag;
  logic [SUM_W-1:0]              term_val;
  logic                          drive_ovf;
  logic [DATA_WIDTH-1:0]         drive_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_update = (in_func == FUNC_UPDATE) && running_r;
  assign out_free  = !out_valid_r || out_ready;

  // Error: setpoint minus sensor, saturated to the data width.
  always_comb begin
    err_wide = {setpoint_r[DATA_WIDTH-1], setpoint_r} - {in_sensor[31], in_sensor};
    err_ovf  = err_wide[DIFF_W-1] ^ err_wide[DIFF_W-2];
    if (err_ovf) begin
      err_nxt = err_wide[DIFF_W-1] ? DATA_MIN : DATA_MAX;
    end else begin
      err_nxt = err_wide[DATA_WIDTH-1:0];
    end
  end

  // Magnitudes; the most negative value maps to its unsigned magnitude.
  always_comb begin
    err_mag   = err_r[DATA_WIDTH-1] ? (~err_r + 1'b1) : err_r;
    diff_mag  = diff_r[DIFF_W-1] ? (~diff_r + 1'b1) : diff_r;
    integ_mag = integral_r[INTEG_W-1] ? (~integral_r + 1'b1) : integral_r;
    kp_mag    = kp_r[DATA_WIDTH-1] ? (~kp_r + 1'b1) : kp_r;
    ki_mag    = ki_r[DATA_WIDTH-1] ? (~ki_r + 1'b1) : ki_r;
    kd_mag    = kd_r[DATA_WIDTH-1] ? (~kd_r + 1'b1) : kd_r;
  end

  // Integral step: add the signed increment, saturate, then apply the cut.
  always_comb begin
    inc_val    = err_r[DATA_WIDTH-1] ? (~{1'b0, div_quo} + 1'b1) : {1'b0, div_quo};
    integ_wide = {integral_r[INTEG_W-1], integral_r} + inc_val;
    integ_ovf  = integ_wide[INTEG_W] ^ integ_wide[INTEG_W-1];
    if (integ_ovf) begin
      integ_sat = integ_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_wide[INTEG_W-1:0];
    end
    cut_hit = cut_en_r && ((err_mag <= {1'b0, thr_r}) ||
                           (err_r[DATA_WIDTH-1] != last_err_r[DATA_WIDTH-1]));
    integral_nxt = cut_hit ? '0 : integ_sat;
    diff_nxt = {err_r[DATA_WIDTH-1], err_r} - {last_err_r[DATA_WIDTH-1], last_err_r};
  end

  // Gain term: (|a|*|k|) >> 16, clamped to 2^60, then signed.
  always_comb begin
    prod_q   = mul_prod[MUL_P_W-1:Q_FRAC];
    term_mag = (prod_q > TERM_LIMIT) ? TERM_LIMIT[TERM_MAG_W-1:0]
                                     : prod_q[TERM_MAG_W-1:0];
    term_val = term_neg ? (~{2'b00, term_mag} + 1'b1) : {2'b00, term_mag};
  end

  always_comb begin
    drive_ovf = !((&sum_r[SUM_W-1:DATA_WIDTH-1]) || !(|sum_r[SUM_W-1:DATA_WIDTH-1]));
    if (drive_ovf) begin
      drive_nxt = sum_r[SUM_W-1] ? DATA_MIN : DATA_MAX;
    end else begin
      drive_nxt = sum_r[DATA_WIDTH-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (accept) state_nxt = is_update ? S_MI_GO : S_DONE;
      S_MI_GO:   state_nxt = S_MI_WAIT;
      S_MI_WAIT: if (mul_done) state_nxt = S_DI_GO;
      S_DI_GO:   state_nxt = S_DI_WAIT;
      S_DI_WAIT: if (div_done) state_nxt = S_INTEG;
      S_INTEG:   state_nxt = S_MD_GO;
      S_MD_GO:   state_nxt = S_MD_WAIT;
      S_MD_WAIT: if (mul_done) state_nxt = S_DD_GO;
      S_DD_GO:   state_nxt = S_DD_WAIT;
      S_DD_WAIT: if (div_done) state_nxt = S_KP_GO;
      S_KP_GO:   state_nxt = S_KP_WAIT;
      S_KP_WAIT: if (mul_done) state_nxt = S_KI_GO;
      S_KI_GO:   state_nxt = S_KI_WAIT;
      S_KI_WAIT: if (mul_done) state_nxt = S_KD_GO;
      S_KD_GO:   state_nxt = S_KD_WAIT;
      S_KD_WAIT: if (mul_done) state_nxt = S_SUM;
      S_SUM:     state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Unit requests and operand selection. The derivative magnitude is read straight
  // from the divider, which stays untouched after the second division.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    term_neg  = 1'b0;
    unique case (state_r)
      S_MI_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(err_mag);
        mul_b     = MUL_B_W'(dt_r);
      end
      S_DI_GO: begin
        div_start = 1'b1;
        div_num   = mul_prod[DIV_N_W-1:0];
        div_den   = DT_SCALE_D;
      end
      S_MD_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(diff_mag);
        mul_b     = DT_SCALE_M;
      end
      S_DD_GO: begin
        div_start = 1'b1;
        div_num   = mul_prod[DIV_N_W-1:0];
        div_den   = dt_r;
      end
      S_KP_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(err_mag);
        mul_b     = kp_mag;
      end
      S_KI_GO: begin
        mul_start = 1'b1;
        mul_a     = integ_mag;
        mul_b     = ki_mag;
      end
      S_KD_GO: begin
        mul_start = 1'b1;
        mul_a     = div_quo;
        mul_b     = kd_mag;
      end
      S_KP_WAIT: term_neg = err_r[DATA_WIDTH-1] ^ kp_r[DATA_WIDTH-1];
      S_KI_WAIT: term_neg = integral_r[INTEG_W-1] ^ ki_r[DATA_WIDTH-1];
      S_KD_WAIT: term_neg = diff_r[DIFF_W-1] ^ kd_r[DATA_WIDTH-1];
      default: begin
      end
    endcase
  end

  pidff_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pidff_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Control state, configuration and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ff_r        <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      setpoint_r  <= '0;
      cut_en_r    <= 1'b0;
      thr_r       <= '0;
      running_r   <= 1'b0;
      integral_r  <= '0;
      last_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FEEDFORWARD:   ff_r       <= cfg_data;
          CFG_KP_GAIN:       kp_r       <= cfg_data;
          CFG_KI_GAIN:       ki_r       <= cfg_data;
          CFG_KD_GAIN:       kd_r       <= cfg_data;
          CFG_CUT_ENABLE:    cut_en_r   <= cfg_data[0];
          CFG_CUT_THRESHOLD: thr_r      <= cfg_data[THR_W-1:0];
          CFG_SETPOINT:      setpoint_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (in_func == FUNC_START) begin
          running_r <= 1'b1;
        end else if (in_func == FUNC_RESET) begin
          running_r  <= 1'b0;
          integral_r <= '0;
          last_err_r <= '0;
        end
      end
      if (state_r == S_INTEG) begin
        integral_r <= integral_nxt;
        last_err_r <= err_r;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      err_r       <= err_nxt;
      dt_r        <= (in_dt_ms == '0) ? DT_W'(1) : in_dt_ms;
      sat_r       <= is_update && err_ovf;
      sum_r       <= {{(SUM_W-DATA_WIDTH){ff_r[DATA_WIDTH-1]}}, ff_r};
      res_drive_r <= '0;
    end
    if (state_r == S_INTEG) begin
      diff_r <= diff_nxt;
      if (integ_ovf) sat_r <= 1'b1;
    end
    if ((state_r == S_KP_WAIT || state_r == S_KI_WAIT || state_r == S_KD_WAIT) &&
        mul_done) begin
      sum_r <= sum_r + term_val;
    end
    if (state_r == S_SUM) begin
      res_drive_r <= drive_nxt;
      if (drive_ovf) sat_r <= 1'b1;
    end
    if (state_r == S_DONE && out_free) begin
      out_drive_r <= res_drive_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

endmodule

// ----- dv/pidff_drive_checker.sv -----
// Checker for the PID controller with feedforward and integral cut: watches the request,
// result and register channels, predicts each drive and compares. Depends on pidff_pkg.
`timescale 1ns / 1ps

module pidff_drive_checker
  import pidff_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [31:0]          in_sensor,
  input  logic [DT_W-1:0]      in_dt_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [31:0]          out_drive,
  input  logic                 out_saturated,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatch_count,
  output int                   pending_results
);

  typedef struct packed {
    logic [31:0] drive;
    logic        sat;
  } drive_result_t;

  localparam longint DATA_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint DATA_LO = -DATA_HI - 1;
  localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint unsigned PRODUCT_CAP = 64'd1 << 60;
  localparam longint unsigned MS_PER_S = 64'd1000;

  // Register shadows.
  longint ff_term, kp, ki, kd, target;
  bit     cut_on;
  longint cut_level;

  // Controller state.
  bit     active;
  longint integ_acc;
  longint prev_err;

  drive_result_t drive_expect_q[$];
  drive_result_t want;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Q16.16 product with the magnitude truncated and capped at 2^60.
  function automatic longint scale_q16(longint a, longint k);
    longint unsigned ma, mk, p;
    longint r;
    ma = magnitude(a);
    mk = magnitude(k);
    p = (ma >> 16) * mk + (((ma & 64'hFFFF) * mk) >> 16);
    if (p > PRODUCT_CAP) p = PRODUCT_CAP;
    r = p;
    return ((a < 0) != (k < 0)) ? -r : r;
  endfunction

  function automatic drive_result_t advance_controller(logic [1:0] func, logic [31:0] sensor,
                                                      logic [DT_W-1:0] dt_ms);
    drive_result_t res;
    longint raw, err, inc, diff, deriv;
    longint unsigned dt, m;
    bit sat;
    sat = 1'b0;
    res.drive = '0;
    if (func == FUNC_START) begin
      active = 1'b1;
    end else if (func == FUNC_RESET) begin
      active = 1'b0;
      integ_acc = 0;
      prev_err = 0;
    end else if (func == FUNC_UPDATE && active) begin
      dt = (dt_ms == '0) ? 64'd1 : 64'(dt_ms);
      raw = target - longint'($signed(sensor));
      err = clip(raw, DATA_LO, DATA_HI);
      sat |= (err != raw);

      m = (magnitude(err) * dt) / MS_PER_S;
      inc = (err < 0) ? -longint'(m) : longint'(m);
      raw = integ_acc + inc;
      integ_acc = clip(raw, INTEG_LO, INTEG_HI);
      sat |= (integ_acc != raw);

      // A zero error counts as non-negative for the sign test.
      if (cut_on && (magnitude(err) <= $unsigned(cut_level) || ((err < 0) != (prev_err < 0))))
        integ_acc = 0;

      diff = err - prev_err;
      m = (magnitude(diff) * MS_PER_S) / dt;
      deriv = (diff < 0) ? -longint'(m) : longint'(m);
      deriv = clip(deriv, INTEG_LO, INTEG_HI);
      prev_err = err;

      raw = ff_term + scale_q16(err, kp) + scale_q16(integ_acc, ki) + scale_q16(deriv, kd);
      res.drive = 32'(clip(raw, DATA_LO, DATA_HI));
      sat |= (clip(raw, DATA_LO, DATA_HI) != raw);
    end
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ff_term = 0; kp = 0; ki = 0; kd = 0; target = 0;
      cut_on = 1'b0; cut_level = 0;
      active = 1'b0; integ_acc = 0; prev_err = 0;
      drive_expect_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expect_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request waiting, drive %h saturated %b",
                   $time, out_drive, out_saturated);
        end else begin
          want = drive_expect_q.pop_front();
          if (out_drive !== want.drive) begin
            mismatch_count++;
            $display("%0t: drive mismatch, expected %h, actual %h",
                     $time, want.drive, out_drive);
          end
          if (out_saturated !== want.sat) begin
            mismatch_count++;
            $display("%0t: saturated mismatch, expected %b, actual %b",
                     $time, want.sat, out_saturated);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FEEDFORWARD:   ff_term = longint'($signed(cfg_data));
          CFG_KP_GAIN:       kp = longint'($signed(cfg_data));
          CFG_KI_GAIN:       ki = longint'($signed(cfg_data));
          CFG_KD_GAIN:       kd = longint'($signed(cfg_data));
          CFG_CUT_ENABLE:    cut_on = cfg_data[0];
          CFG_CUT_THRESHOLD: cut_level = longint'(cfg_data[THR_W-1:0]);
          CFG_SETPOINT:      target = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_expect_q.push_back(advance_controller(in_func, in_sensor, in_dt_ms));
    end
    pending_results = drive_expect_q.size();
  end

endmodule

// ----- dv/tb_pid_feedforward_integral_cut_unit.sv -----
// Testbench top for pid_feedforward_integral_cut_unit: clock, reset, register writes,
// request stimulus and result back-pressure. Depends on pidff_pkg and pidff_drive_checker.
`timescale 1ns / 1ps

module tb_pid_feedforward_integral_cut_unit;
  import pidff_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int STUCK_LIMIT = 20000;
  localparam int DRAIN_TAIL = 300;

  typedef enum int {GAINS_TYPICAL, GAINS_FULL, GAINS_EXTREME} gain_mix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [31:0]          in_sensor;
  logic [DT_W-1:0]      in_dt_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          out_drive;
  logic                 out_saturated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int mismatch_count;
  int pending_results;

  logic [31:0] reg_val [8];
  bit no_idle = 1'b0;
  int hold_seq = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  int stuck_cycles = 0;

  pid_feedforward_integral_cut_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_sensor     (in_sensor),
    .in_dt_ms      (in_dt_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pidff_drive_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_sensor       (in_sensor),
    .in_dt_ms        (in_dt_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive       (out_drive),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly no gap, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 18) return 16'($urandom);
    return 16'($urandom_range(1, 50));
  endfunction

  function automatic logic [31:0] pick_q(gain_mix_t mix);
    logic [31:0] v;
    case (mix)
      GAINS_FULL: v = $urandom;
      GAINS_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h0002_0000);
        if ($urandom_range(0, 3) == 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // The result receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != rx_hold_seen) begin
        rx_hold_seen = hold_seq;
        rx_hold_left = HOLD_OFF_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] f, input logic [31:0] s, input logic [15:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_sensor <= s;
    in_dt_ms  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering requests and let every outstanding result come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_all_regs();
    for (int i = CFG_FEEDFORWARD; i <= CFG_SETPOINT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] ff, input logic [31:0] p, input logic [31:0] i,
                          input logic [31:0] d, input logic [31:0] en,
                          input logic [31:0] thr, input logic [31:0] sp);
    reg_val[CFG_FEEDFORWARD]   = ff;
    reg_val[CFG_KP_GAIN]       = p;
    reg_val[CFG_KI_GAIN]       = i;
    reg_val[CFG_KD_GAIN]       = d;
    reg_val[CFG_CUT_ENABLE]    = en;
    reg_val[CFG_CUT_THRESHOLD] = thr;
    reg_val[CFG_SETPOINT]      = sp;
    write_all_regs();
  endtask

  task automatic load_random_regs(input gain_mix_t mix);
    logic [31:0] thr, sp;
    if (mix == GAINS_TYPICAL) begin
      thr = {1'($urandom), 31'($urandom_range(0, 32'h0002_0000))};
      sp  = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    end else begin
      thr = pick_q(mix);
      sp  = pick_q(mix);
    end
    set_regs(pick_q(mix), pick_q(mix), pick_q(mix), pick_q(mix),
             {31'($urandom), 1'($urandom_range(0, 2) != 0)}, thr, sp);
  endtask

  // Mostly bursts of updates around the setpoint, with starts, resets and noise mixed in.
  task automatic run_phase(input int n_items, input int spread);
    int sent, burst, r;
    send_req(FUNC_START, $urandom, 16'($urandom));
    sent = 1;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_req(FUNC_RESET, $urandom, 16'($urandom));
      end else if (r < 14) begin
        send_req(FUNC_START, $urandom, 16'($urandom));
      end else if (r < 17) begin
        send_req(FUNC_SPARE, $urandom, 16'($urandom));
      end else if (r < 22) begin
        send_req(FUNC_UPDATE, $urandom, pick_dt());
      end else if (r < 25) begin
        send_req(FUNC_UPDATE, pick_q(GAINS_EXTREME), pick_dt());
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send_req(FUNC_UPDATE, reg_val[CFG_SETPOINT] + 32'($urandom_range(0, 2 * spread))
                   - 32'(spread), pick_dt());
        end
        sent += burst - 1;
      end
      sent++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FUNC_UPDATE;
    in_sensor = '0;
    in_dt_ms  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FEEDFORWARD;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: moderate gains with the cut enabled.
    set_regs(32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0000_0100,
             32'h0000_0001, 32'h0000_1000, 32'h0005_0000);
    send_req(FUNC_UPDATE, 32'h0000_0000, 16'd10);       // update while stopped
    send_req(FUNC_START, 32'h0000_0000, 16'd0);
    send_req(FUNC_START, 32'hFFFF_FFFF, 16'hFFFF);      // start while already running
    send_req(FUNC_UPDATE, 32'h0004_0000, 16'd10);
    send_req(FUNC_UPDATE, 32'h0006_0000, 16'd0);        // sign flip and zero dt
    send_req(FUNC_UPDATE, 32'h0005_0000, 16'hFFFF);     // zero error
    send_req(FUNC_UPDATE, 32'h0004_F000, 16'd5);        // error right at the threshold
    send_req(FUNC_UPDATE, 32'h8000_0000, 16'hFFFF);     // error saturates high
    send_req(FUNC_UPDATE, 32'h7FFF_FFFF, 16'd1);        // large negative error, short of saturation
    send_req(FUNC_SPARE, 32'h1234_5678, 16'd77);
    send_req(FUNC_UPDATE, 32'hFFFF_FFFF, 16'd20);
    send_req(FUNC_RESET, 32'h0000_0000, 16'd0);
    send_req(FUNC_UPDATE, 32'h0001_0000, 16'd10);       // stopped after the reset
    send_req(FUNC_START, 32'h0000_0000, 16'd0);
    send_req(FUNC_UPDATE, 32'h0000_0000, 16'd100);
    send_req(FUNC_UPDATE, 32'h0004_FFFF, 16'd1000);

    // Directed: every register at its positive extreme, cut disabled.
    wait_drain();
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(FUNC_UPDATE, 32'h8000_0000, 16'hFFFF);
    send_req(FUNC_UPDATE, 32'h7FFF_FFFF, 16'd1);
    send_req(FUNC_UPDATE, 32'h0000_0000, 16'd0);

    // Directed: negative extremes, cut enabled with a zero threshold.
    wait_drain();
    set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
    send_req(FUNC_UPDATE, 32'h7FFF_FFFF, 16'hFFFF);
    send_req(FUNC_UPDATE, 32'h8000_0000, 16'd1);
    send_req(FUNC_UPDATE, 32'h8000_0001, 16'd2);
    send_req(FUNC_RESET, 32'hFFFF_FFFF, 16'hFFFF);

    for (int phase = 0; phase < 8; phase++) begin
      wait_drain();
      no_idle = (phase == 3);
      if (phase % 4 == 1)
        load_random_regs(GAINS_FULL);
      else if (phase % 4 == 3)
        load_random_regs(GAINS_EXTREME);
      else
        load_random_regs(GAINS_TYPICAL);
      // The receiver stops for a long while so the block backs up onto its input.
      if (phase == 5) hold_seq++;
      run_phase(125, (phase % 2 == 1) ? 32'h0000_4000 : 32'h0004_0000);
    end
    no_idle = 1'b0;

    wait_drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pidff_pkg.sv
rtl/pidff_mul.sv
rtl/pidff_div.sv
rtl/pid_feedforward_integral_cut_unit.sv
dv/pidff_drive_checker.sv
dv/tb_pid_feedforward_integral_cut_unit.sv
